// ===== rtl/stwe_pkg.sv =====
// Shared types and constants of the subscription table with expiry.
package stwe_pkg;

    localparam int TYPE_W      = 10;
    localparam int INST_W      = 22;
    localparam int PROC_W      = 32;
    localparam int RCPT_W      = 16;
    localparam int LIFE_W      = 32;
    localparam int OUT_IDX_W   = 4;
    localparam int MAX_NOTES   = 16;
    localparam int NOTE_CW     = $clog2(MAX_NOTES + 1);
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 120;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TYPE_W-1:0] NOTIFY_TYPE_RESET = TYPE_W'(3);

    typedef enum logic [1:0] {
        OP_SUBSCRIBE = 2'd0,
        OP_TICK      = 2'd1,
        OP_CHANGE    = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_ERR  = 2'd1,
        KIND_NOTE = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RSN_UNKNOWN = 2'd0,
        RSN_NORES   = 2'd1,
        RSN_NOSUB   = 2'd2
    } t_reason;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0] obj_type;
        logic [INST_W-1:0] inst;
        logic [PROC_W-1:0] process;
        logic [RCPT_W-1:0] recipient;
        logic              confirmed;
        logic [LIFE_W-1:0] lifetime;
    } t_entry;

    typedef struct packed {
        t_entry            entry;
        logic              cancel;
        logic              known;
        logic [LIFE_W-1:0] elapsed;
    } t_req;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic ev_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ev_block;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/stwe_dp.sv =====
// Datapath: entry memory, valid and pending bits, request latch and result register.
module stwe_dp #(
    parameter  int ENTRIES = 16,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stwe_pkg::t_cmd                i_cmd,
    input  logic [IW-1:0]                 i_rd_idx,
    input  logic [IW-1:0]                 i_ev_idx,
    input  stwe_pkg::t_op                 i_in_op,
    input  stwe_pkg::t_req                i_in_req,
    input  logic [stwe_pkg::TYPE_W-1:0]   i_notify_type,
    input  logic                          i_out_ready,
    output stwe_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output stwe_pkg::t_kind               o_out_kind,
    output stwe_pkg::t_reason             o_out_reason,
    output logic [stwe_pkg::OUT_IDX_W-1:0] o_out_idx,
    output stwe_pkg::t_entry              o_out_entry,
    output logic                          o_out_last
);
    import stwe_pkg::*;

    t_entry               r_mem [ENTRIES];
    t_entry               r_rd_data;
    logic [ENTRIES-1:0]   r_valid;
    logic [ENTRIES-1:0]   r_pending;
    t_req                 r_req;
    t_op                  r_op;
    logic                 r_match_found;
    logic                 r_free_found;
    logic [IW-1:0]        r_match_idx;
    logic [IW-1:0]        r_free_idx;
    logic [NOTE_CW-1:0]   r_notes;

    logic                 r_out_valid;
    t_kind                r_out_kind;
    t_reason              r_out_reason;
    logic [OUT_IDX_W-1:0] r_out_idx;
    t_entry               r_out_entry;
    logic                 r_out_last;

    logic                 ev_v;
    logic                 ev_p;
    logic                 hit_sub;
    logic                 hit_chg;
    logic [LIFE_W-1:0]    new_life;
    logic                 tick_note;
    logic                 out_free;
    t_entry               tick_entry;
    logic                 req_ok;
    t_kind                fin_kind;
    t_reason              fin_reason;
    logic                 fin_write;
    logic                 fin_cancel;
    logic [IW-1:0]        fin_idx;
    logic                 we;
    logic [IW-1:0]        waddr;
    t_entry               wdata;

    assign ev_v = r_valid[i_ev_idx];
    assign ev_p = r_pending[i_ev_idx];

    assign hit_sub = ev_v && (r_rd_data.obj_type == r_req.entry.obj_type)
                     && (r_rd_data.inst == r_req.entry.inst)
                     && (r_rd_data.process == r_req.entry.process);
    assign hit_chg = ev_v && (r_rd_data.obj_type == i_notify_type)
                     && (r_rd_data.inst == r_req.entry.inst);

    assign new_life = (r_rd_data.lifetime >= r_req.elapsed) ?
                      (r_rd_data.lifetime - r_req.elapsed) : '0;

    assign tick_note = (r_op == OP_TICK) && ev_v && ev_p
                       && (r_notes < NOTE_CW'(MAX_NOTES));
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_status.ev_block = tick_note && !out_free;
    assign o_status.out_free = out_free;

    always_comb begin
        tick_entry          = r_rd_data;
        tick_entry.lifetime = new_life;
    end

    assign req_ok = (r_req.entry.obj_type == i_notify_type) && r_req.known;

    always_comb begin
        fin_kind   = KIND_ACK;
        fin_reason = RSN_UNKNOWN;
        fin_write  = 1'b0;
        fin_cancel = 1'b0;
        fin_idx    = r_free_idx;
        case (r_op)
            OP_SUBSCRIBE: begin
                if (!req_ok) begin
                    fin_kind   = KIND_ERR;
                    fin_reason = RSN_UNKNOWN;
                end else if (r_match_found) begin
                    fin_idx = r_match_idx;
                    if (r_req.cancel) begin
                        fin_cancel = 1'b1;
                    end else begin
                        fin_write = 1'b1;
                    end
                end else if (!r_free_found) begin
                    fin_kind   = KIND_ERR;
                    fin_reason = RSN_NORES;
                end else if (r_req.cancel) begin
                    fin_kind   = KIND_ERR;
                    fin_reason = RSN_NOSUB;
                end else begin
                    fin_write = 1'b1;
                end
            end
            default: begin
                fin_kind = KIND_DONE;
            end
        endcase
    end

    assign we    = (i_cmd.ev_en && (r_op == OP_TICK) && ev_v) || (i_cmd.finish && fin_write);
    assign waddr = i_cmd.finish ? fin_idx : i_ev_idx;
    assign wdata = i_cmd.finish ? r_req.entry : tick_entry;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_pending     <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_idx   <= '0;
            r_free_idx    <= '0;
            r_notes       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
                r_notes       <= '0;
            end
            if (i_cmd.ev_en) begin
                case (r_op)
                    OP_SUBSCRIBE: begin
                        if (hit_sub && !r_match_found) begin
                            r_match_found <= 1'b1;
                            r_match_idx   <= i_ev_idx;
                        end
                        if (!ev_v && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= i_ev_idx;
                        end
                    end
                    OP_TICK: begin
                        if (ev_v && (new_life == '0)) begin
                            r_valid[i_ev_idx] <= 1'b0;
                        end
                        if (tick_note) begin
                            r_pending[i_ev_idx] <= 1'b0;
                            r_notes             <= r_notes + NOTE_CW'(1);
                        end
                    end
                    OP_CHANGE: begin
                        if (hit_chg) begin
                            r_pending[i_ev_idx] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.finish) begin
                if (fin_cancel) begin
                    r_valid[fin_idx]   <= 1'b0;
                    r_pending[fin_idx] <= 1'b0;
                end
                if (fin_write) begin
                    r_valid[fin_idx]   <= 1'b1;
                    r_pending[fin_idx] <= 1'b1;
                end
            end
            if ((i_cmd.ev_en && tick_note) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_req;
            r_op  <= i_in_op;
        end
        if (i_cmd.ev_en && tick_note) begin
            r_out_kind   <= KIND_NOTE;
            r_out_reason <= RSN_UNKNOWN;
            r_out_idx    <= OUT_IDX_W'(i_ev_idx);
            r_out_entry  <= tick_entry;
            r_out_last   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_kind   <= fin_kind;
            r_out_reason <= fin_reason;
            r_out_idx    <= '0;
            r_out_entry  <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_reason = r_out_reason;
    assign o_out_idx    = r_out_idx;
    assign o_out_entry  = r_out_entry;
    assign o_out_last   = r_out_last;

endmodule

// ===== rtl/stwe_ctrl.sv =====
// Controller: accepts a word, walks the table one entry per cycle while not stalled and closes with a final result.
module stwe_ctrl #(
    parameter  int ENTRIES = 16,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  stwe_pkg::t_status   i_status,
    output logic                o_in_ready,
    output stwe_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]       o_rd_idx,
    output logic [IW-1:0]       o_ev_idx
);
    import stwe_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_rd_cnt;
    logic [CW-1:0] n_rd_cnt;
    logic          r_ev_vld;
    logic          n_ev_vld;
    logic [IW-1:0] r_ev_idx;
    logic [IW-1:0] n_ev_idx;
    logic          rd_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_cnt <= '0;
            r_ev_vld <= 1'b0;
            r_ev_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_cnt <= n_rd_cnt;
            r_ev_vld <= n_ev_vld;
            r_ev_idx <= n_ev_idx;
        end
    end

    assign rd_go = (r_rd_cnt != CW'(ENTRIES));

    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_rd_cnt      = '0;
                    n_ev_vld      = 1'b0;
                    n_state       = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!(r_ev_vld && i_status.ev_block)) begin
                    o_cmd.ev_en = r_ev_vld;
                    o_cmd.rd_en = rd_go;
                    n_ev_vld    = rd_go;
                    n_ev_idx    = r_rd_cnt[IW-1:0];
                    if (rd_go) begin
                        n_rd_cnt = r_rd_cnt + CW'(1);
                    end else if (!r_ev_vld) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_idx = r_rd_cnt[IW-1:0];
    assign o_ev_idx = r_ev_idx;

endmodule

// ===== rtl/subscription_table_with_expiry.sv =====
// Top level of the subscription table with expiry: ports, configuration register, assertions.
//
//   channel   direction  handshake                 contents
//   s_axis    in         s_axis_tvalid/tready      one operation word
//   m_axis    out        m_axis_tvalid/tready      ack, error, notifications, done
//   apb       in/out     psel, penable, pready     notify_object_type register
//
// Every word walks all ENTRIES slots, one slot a cycle through the single read port of the
// entry memory, while the output side keeps up. A stalled output holds the walk on the entry
// that has a notification ready. Reset is synchronous and active low; it clears all valid
// and pending bits at once.
module subscription_table_with_expiry #(
    parameter int ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // object_type, object_instance, process_id, cancel_request, confirmed,
    // lifetime, recipient, object_known, elapsed_time, zero fill
    input  logic [stwe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // error_reason, entry_index, notify_recipient, notify_process, notify_type,
    // notify_instance, time_remaining, notify_confirmed, zero fill
    output logic [stwe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // result_kind
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stwe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [stwe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [stwe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import stwe_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [TYPE_W-1:0]    r_notify_type;
    t_req                 in_req;
    t_op                  in_op;
    t_cmd                 cmd;
    t_status              status;
    logic [IW-1:0]        rd_idx;
    logic [IW-1:0]        ev_idx;
    t_kind                out_kind;
    t_reason              out_reason;
    logic [OUT_IDX_W-1:0] out_idx;
    t_entry               out_entry;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_type <= NOTIFY_TYPE_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_notify_type <= pwdata[TYPE_W-1:0];
        end
    end

    assign prdata = paddr[2] ? '0 : CFG_DATA_W'(r_notify_type);

    assign in_op                  = t_op'(s_axis_tuser);
    assign in_req.entry.obj_type  = s_axis_tdata[9:0];
    assign in_req.entry.inst      = s_axis_tdata[31:10];
    assign in_req.entry.process   = s_axis_tdata[63:32];
    assign in_req.cancel          = s_axis_tdata[64];
    assign in_req.entry.confirmed = s_axis_tdata[65];
    assign in_req.entry.lifetime  = s_axis_tdata[97:66];
    assign in_req.entry.recipient = s_axis_tdata[113:98];
    assign in_req.known           = s_axis_tdata[114];
    assign in_req.elapsed         = s_axis_tdata[146:115];

    stwe_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx),
        .o_ev_idx   (ev_idx)
    );

    stwe_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_idx      (rd_idx),
        .i_ev_idx      (ev_idx),
        .i_in_op       (in_op),
        .i_in_req      (in_req),
        .i_notify_type (r_notify_type),
        .i_out_ready   (m_axis_tready),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .o_out_kind    (out_kind),
        .o_out_reason  (out_reason),
        .o_out_idx     (out_idx),
        .o_out_entry   (out_entry),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {1'b0, out_entry.confirmed, out_entry.lifetime, out_entry.inst,
                           out_entry.obj_type, out_entry.process, out_entry.recipient,
                           out_idx, out_reason};

`ifndef SYNTHESIS
    // The block works on one word at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is still in work");

    // Only the closing result of a word is marked last.
    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_NOTE)))
        else $error("last flag does not match result kind");

    // Error reason is zero on all but error results.
    a_reason_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_ERR) |-> m_axis_tdata[1:0] == RSN_UNKNOWN)
        else $error("error reason set on a non-error result");
`endif

endmodule

// ===== bench/subscription_table_with_expiry_checker.sv =====
// Checker of the subscription table: tracks the table and compares every result word.
`timescale 1ns / 1ps

module subscription_table_with_expiry_checker #(
    parameter int                                ENTRIES          = 16,
    parameter logic [stwe_pkg::CFG_ADDR_W-1:0]   NOTIFY_TYPE_ADDR = '0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [stwe_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic [1:0]                         i_in_op,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [stwe_pkg::OUT_TDATA_W-1:0]   i_out_data,
    input  logic [1:0]                         i_out_kind,
    input  logic                               i_out_last,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [stwe_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [stwe_pkg::CFG_DATA_W-1:0]    i_pwdata,
    input  logic [stwe_pkg::CFG_DATA_W-1:0]    i_prdata,
    output int                                 o_awaited,
    output int                                 o_fail_count
);
    import stwe_pkg::*;

    typedef struct {
        t_kind             kind;
        logic [1:0]        reason;
        logic [3:0]        slot;
        logic [RCPT_W-1:0] recipient;
        logic [PROC_W-1:0] process;
        logic [TYPE_W-1:0] obj_type;
        logic [INST_W-1:0] inst;
        logic [LIFE_W-1:0] remaining;
        logic              confirmed;
        logic              last;
    } t_result;

    logic [TYPE_W-1:0] watch_type;
    logic              slot_valid     [ENTRIES];
    logic [TYPE_W-1:0] slot_type      [ENTRIES];
    logic [INST_W-1:0] slot_inst      [ENTRIES];
    logic [PROC_W-1:0] slot_process   [ENTRIES];
    logic [RCPT_W-1:0] slot_recipient [ENTRIES];
    logic              slot_confirmed [ENTRIES];
    logic [LIFE_W-1:0] slot_lifetime  [ENTRIES];
    logic              slot_pending   [ENTRIES];
    t_result           awaited_results[$];
    t_result           head;
    int                failures = 0;

    initial begin
        o_awaited    = 0;
        o_fail_count = 0;
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic void push_closing(t_kind kind, logic [1:0] reason);
        t_result r;
        r = '{kind: kind, reason: reason, default: '0};
        r.last = 1'b1;
        awaited_results.push_back(r);
    endfunction

    task automatic subscription_step(input t_op op, input logic [IN_TDATA_W-1:0] d);
        logic [TYPE_W-1:0] typ;
        logic [INST_W-1:0] inst;
        logic [PROC_W-1:0] proc;
        logic              cancel;
        logic              conf;
        logic [LIFE_W-1:0] life;
        logic [RCPT_W-1:0] rcpt;
        logic              known;
        logic [LIFE_W-1:0] elapsed;
        int                free_slot;
        int                notes;
        int                i;
        bit                hit;
        t_result           r;
        typ     = d[9:0];
        inst    = d[31:10];
        proc    = d[63:32];
        cancel  = d[64];
        conf    = d[65];
        life    = d[97:66];
        rcpt    = d[113:98];
        known   = d[114];
        elapsed = d[146:115];
        case (op)
            OP_SUBSCRIBE: begin
                if (typ != watch_type || !known) begin
                    push_closing(KIND_ERR, RSN_UNKNOWN);
                end else begin
                    hit       = 1'b0;
                    free_slot = -1;
                    for (i = 0; i < ENTRIES && !hit; i++) begin
                        if (slot_valid[i]) begin
                            if (slot_type[i] == typ && slot_inst[i] == inst &&
                                slot_process[i] == proc) begin
                                hit = 1'b1;
                                if (cancel) begin
                                    slot_valid[i]   = 1'b0;
                                    slot_pending[i] = 1'b0;
                                end else begin
                                    slot_recipient[i] = rcpt;
                                    slot_confirmed[i] = conf;
                                    slot_lifetime[i]  = life;
                                    slot_pending[i]   = 1'b1;
                                end
                            end
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit) begin
                        push_closing(KIND_ACK, RSN_UNKNOWN);
                    end else if (free_slot < 0) begin
                        push_closing(KIND_ERR, RSN_NORES);
                    end else if (cancel) begin
                        push_closing(KIND_ERR, RSN_NOSUB);
                    end else begin
                        slot_valid[free_slot]     = 1'b1;
                        slot_type[free_slot]      = typ;
                        slot_inst[free_slot]      = inst;
                        slot_process[free_slot]   = proc;
                        slot_recipient[free_slot] = rcpt;
                        slot_confirmed[free_slot] = conf;
                        slot_lifetime[free_slot]  = life;
                        slot_pending[free_slot]   = 1'b1;
                        push_closing(KIND_ACK, RSN_UNKNOWN);
                    end
                end
            end
            OP_TICK: begin
                notes = 0;
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i]) begin
                        slot_lifetime[i] = (slot_lifetime[i] >= elapsed) ?
                                           slot_lifetime[i] - elapsed : '0;
                        if (slot_lifetime[i] == '0) begin
                            slot_valid[i] = 1'b0;
                        end
                        if (slot_pending[i] && notes < MAX_NOTES) begin
                            r.kind      = KIND_NOTE;
                            r.reason    = RSN_UNKNOWN;
                            r.slot      = i[3:0];
                            r.recipient = slot_recipient[i];
                            r.process   = slot_process[i];
                            r.obj_type  = slot_type[i];
                            r.inst      = slot_inst[i];
                            r.remaining = slot_lifetime[i];
                            r.confirmed = slot_confirmed[i];
                            r.last      = 1'b0;
                            awaited_results.push_back(r);
                            slot_pending[i] = 1'b0;
                            notes++;
                        end
                    end
                end
                push_closing(KIND_DONE, RSN_UNKNOWN);
            end
            OP_CHANGE: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i] && slot_type[i] == watch_type && slot_inst[i] == inst) begin
                        slot_pending[i] = 1'b1;
                    end
                end
                push_closing(KIND_DONE, RSN_UNKNOWN);
            end
            default: begin
                push_closing(KIND_DONE, RSN_UNKNOWN);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            watch_type = NOTIFY_TYPE_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i]     = 1'b0;
                slot_type[i]      = '0;
                slot_inst[i]      = '0;
                slot_process[i]   = '0;
                slot_recipient[i] = '0;
                slot_confirmed[i] = 1'b0;
                slot_lifetime[i]  = '0;
                slot_pending[i]   = 1'b0;
            end
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == NOTIFY_TYPE_ADDR) begin
                if (i_pwrite) begin
                    watch_type = i_pwdata[TYPE_W-1:0];
                end else begin
                    check_field("prdata", 64'(watch_type), 64'(i_prdata));
                end
            end
            if (i_in_valid && i_in_ready) begin
                subscription_step(t_op'(i_in_op), i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with none expected: result_kind %0d", i_out_kind);
                    failures++;
                end else begin
                    head = awaited_results.pop_front();
                    check_field("result_kind", 64'(head.kind), 64'(i_out_kind));
                    check_field("error_reason", 64'(head.reason), 64'(i_out_data[1:0]));
                    check_field("entry_index", 64'(head.slot), 64'(i_out_data[5:2]));
                    check_field("notify_recipient", 64'(head.recipient),
                                64'(i_out_data[21:6]));
                    check_field("notify_process", 64'(head.process), 64'(i_out_data[53:22]));
                    check_field("notify_type", 64'(head.obj_type), 64'(i_out_data[63:54]));
                    check_field("notify_instance", 64'(head.inst), 64'(i_out_data[85:64]));
                    check_field("time_remaining", 64'(head.remaining),
                                64'(i_out_data[117:86]));
                    check_field("notify_confirmed", 64'(head.confirmed),
                                64'(i_out_data[118]));
                    check_field("last", 64'(head.last), 64'(i_out_last));
                end
            end
        end
        o_awaited    <= awaited_results.size();
        o_fail_count <= failures;
    end

endmodule

// ===== bench/subscription_table_with_expiry_test.sv =====
// Top of the subscription table bench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module subscription_table_with_expiry_test;
    import stwe_pkg::*;

    localparam int                      ENTRIES          = 16;
    localparam int                      CYCLE_LIMIT      = 400000;
    localparam int                      LONG_HOLD        = 400;
    localparam int                      WORDS_PER_PHASE  = 49;
    localparam logic [CFG_ADDR_W-1:0]   NOTIFY_TYPE_ADDR = '0;

    typedef struct {
        t_op               op;
        logic [TYPE_W-1:0] obj_type;
        logic [INST_W-1:0] inst;
        logic [PROC_W-1:0] process;
        logic              cancel;
        logic              confirmed;
        logic [LIFE_W-1:0] lifetime;
        logic [RCPT_W-1:0] recipient;
        logic              known;
        logic [LIFE_W-1:0] elapsed;
    } t_word;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]              s_axis_tuser  = OP_NONE;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]              m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr         = '0;
    logic [CFG_DATA_W-1:0]   pwdata        = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    int                      awaited;
    int                      fail_count;
    int                      cycle_count   = 0;
    bit                      steady_sender = 1'b0;
    bit                      steady_sink   = 1'b0;
    bit                      long_hold_req = 1'b0;
    logic [TYPE_W-1:0]       notify_type   = NOTIFY_TYPE_RESET;

    always #2 i_clk = ~i_clk;

    subscription_table_with_expiry #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    subscription_table_with_expiry_checker #(
        .ENTRIES          (ENTRIES),
        .NOTIFY_TYPE_ADDR (NOTIFY_TYPE_ADDR)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_kind   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_awaited    (awaited),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_word random_word();
        t_word w;
        w.op        = t_op'($urandom_range(3));
        w.obj_type  = TYPE_W'($urandom_range(1023));
        w.inst      = INST_W'($urandom_range(4194303));
        w.process   = $urandom;
        w.cancel    = 1'($urandom_range(1));
        w.confirmed = 1'($urandom_range(1));
        w.lifetime  = $urandom;
        w.recipient = RCPT_W'($urandom_range(65535));
        w.known     = 1'($urandom_range(1));
        w.elapsed   = $urandom;
        return w;
    endfunction

    task automatic send_word(input t_word w);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= {5'b0, w.elapsed, w.known, w.recipient, w.lifetime, w.confirmed,
                          w.cancel, w.process, w.inst, w.obj_type};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
        repeat (ENTRIES + 8) @(posedge i_clk);
    endtask

    // Writes the watched object type and reads it back through the same port.
    task automatic write_notify_type(input logic [TYPE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NOTIFY_TYPE_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        notify_type = value;
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = steady_sink ? 0 : $urandom_range(6);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stimulus
        t_word             w;
        logic [INST_W-1:0] inst_pool [6];
        logic [PROC_W-1:0] proc_pool [4];
        int                phase;
        int                n;
        int                pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Refusals on an empty table.
        w = random_word();
        w.op       = OP_SUBSCRIBE;
        w.obj_type = notify_type;
        w.known    = 1'b0;
        send_word(w);
        w = random_word();
        w.op       = OP_SUBSCRIBE;
        w.obj_type = 10'd1023;
        w.known    = 1'b1;
        send_word(w);
        w = random_word();
        w.op       = OP_SUBSCRIBE;
        w.obj_type = notify_type;
        w.known    = 1'b1;
        w.cancel   = 1'b1;
        send_word(w);

        // Fill every slot, with the field extremes in the first two slots and the last slot.
        for (n = 0; n < ENTRIES; n++) begin
            w = random_word();
            w.op        = OP_SUBSCRIBE;
            w.obj_type  = notify_type;
            w.known     = 1'b1;
            w.cancel    = 1'b0;
            w.inst      = (n == 0) ? '0 : (n == 1) ? '1 : INST_W'(n);
            w.process   = (n == ENTRIES - 1) ? '1 : PROC_W'(n);
            w.lifetime  = (n == 0) ? '0 : (n == 1) ? '1 : LIFE_W'(100);
            w.recipient = (n == 1) ? '1 : RCPT_W'(n);
            w.confirmed = n[0];
            send_word(w);
        end

        // Full table: a new subscription and a cancel of an unknown one both run out.
        w.inst   = 22'd4000;
        w.cancel = 1'b0;
        send_word(w);
        w.cancel = 1'b1;
        send_word(w);
        w = random_word();
        w.op        = OP_SUBSCRIBE;
        w.obj_type  = notify_type;
        w.known     = 1'b1;
        w.cancel    = 1'b0;
        w.inst      = 22'd3;
        w.process   = 32'd3;
        w.lifetime  = 32'd7;
        send_word(w);
        w = random_word();
        w.op      = OP_TICK;
        w.elapsed = '0;
        send_word(w);
        w = random_word();
        w.op   = OP_CHANGE;
        w.inst = '1;
        send_word(w);
        w = random_word();
        w.op       = OP_SUBSCRIBE;
        w.obj_type = notify_type;
        w.known    = 1'b1;
        w.cancel   = 1'b1;
        w.inst     = 22'd2;
        w.process  = 32'd2;
        send_word(w);
        w = random_word();
        w.op = OP_NONE;
        send_word(w);
        w = random_word();
        w.op      = OP_TICK;
        w.elapsed = '1;
        send_word(w);

        for (phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                1: write_notify_type(10'd1023);
                2: write_notify_type(10'd0);
                3: write_notify_type(TYPE_W'($urandom_range(1023)));
                4: write_notify_type(NOTIFY_TYPE_RESET);
                default: ;
            endcase
            inst_pool[0] = '0;
            inst_pool[1] = '1;
            for (n = 2; n < 6; n++) begin
                inst_pool[n] = INST_W'($urandom_range(4194303));
            end
            proc_pool[0] = '0;
            proc_pool[1] = '1;
            proc_pool[2] = $urandom;
            proc_pool[3] = $urandom;
            steady_sender = ($urandom_range(3) == 0);
            steady_sink   = ($urandom_range(3) == 0);
            if (phase == 1) begin
                long_hold_req = 1'b1;
            end
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                w    = random_word();
                pick = $urandom_range(99);
                if (pick < 55) begin
                    w.op       = OP_SUBSCRIBE;
                    w.obj_type = notify_type;
                    w.known    = 1'b1;
                    w.inst     = inst_pool[$urandom_range(5)];
                    w.process  = proc_pool[$urandom_range(3)];
                    w.cancel   = ($urandom_range(4) == 0);
                    case ($urandom_range(9))
                        0:       w.lifetime = '0;
                        1:       w.lifetime = '1;
                        2, 3:    w.lifetime = $urandom;
                        default: w.lifetime = $urandom_range(30, 1);
                    endcase
                end else if (pick < 63) begin
                    w.op = OP_SUBSCRIBE;
                    if ($urandom_range(1)) begin
                        w.obj_type = notify_type;
                    end
                end else if (pick < 80) begin
                    w.op = OP_TICK;
                    case ($urandom_range(9))
                        0:       w.elapsed = '0;
                        1:       w.elapsed = '1;
                        2:       w.elapsed = $urandom;
                        default: w.elapsed = $urandom_range(8, 1);
                    endcase
                end else if (pick < 95) begin
                    w.op = OP_CHANGE;
                    if ($urandom_range(4) != 0) begin
                        w.inst = inst_pool[$urandom_range(5)];
                    end
                end else begin
                    w.op = OP_NONE;
                end
                send_word(w);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
